>>> src/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// shared widths, register indexes, sideband type and arctangent table
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int MAX_CAMERAS    = 2;
  localparam int CAM_SETS       = 2;
  localparam int CAM_USED       = (MAX_CAMERAS < CAM_SETS) ? MAX_CAMERAS : CAM_SETS;
  localparam int BEARING_STAGES = 16;
  localparam int TABLE_LEN      = 24;
  localparam int XW             = 36;
  localparam int ZW             = 32;
  localparam int SQW            = 33;

  typedef enum logic [2:0] {
    REG_COUNT    = 3'd0,
    REG_CENTER_0 = 3'd1,
    REG_WIDTH_0  = 3'd2,
    REG_RANGE_0  = 3'd3,
    REG_CENTER_1 = 3'd4,
    REG_WIDTH_1  = 3'd5,
    REG_RANGE_1  = 3'd6
  } csd_reg_t;

  // target data riding alongside the bearing pipeline
  typedef struct packed {
    logic [15:0]    tx;
    logic [15:0]    ty;
    logic           last;
    logic           zero;
    logic [SQW-1:0] dx2;
    logic [SQW-1:0] dy2;
  } csd_side_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [ZW-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage

>>> src/csd_cordic.sv
// ----------------------------------------------------------------------------
// csd_cordic
// vectoring cordic pipeline, one registered step per stage
// ----------------------------------------------------------------------------
module csd_cordic
  import csd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic [ZW-1:0]        in_z,
  input  csd_side_t            in_side,
  output logic                 out_vld,
  output logic [ZW-1:0]        out_z,
  output csd_side_t            out_side
);

  logic                 vld_r  [BEARING_STAGES];
  logic signed [XW-1:0] x_r    [BEARING_STAGES];
  logic signed [XW-1:0] y_r    [BEARING_STAGES];
  logic [ZW-1:0]        z_r    [BEARING_STAGES];
  csd_side_t            side_r [BEARING_STAGES];

  for (genvar i = 0; i < BEARING_STAGES; i++) begin : g_step
    logic                 vld_p;
    logic signed [XW-1:0] x_p;
    logic signed [XW-1:0] y_p;
    logic [ZW-1:0]        z_p;
    csd_side_t            side_p;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    if (i == 0) begin : g_first
      assign vld_p  = in_vld;
      assign x_p    = in_x;
      assign y_p    = in_y;
      assign z_p    = in_z;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[i-1];
      assign x_p    = x_r[i-1];
      assign y_p    = y_r[i-1];
      assign z_p    = z_r[i-1];
      assign side_p = side_r[i-1];
    end

    assign xs = x_p >>> i;
    assign ys = y_p >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_p;
        if (!y_p[XW-1]) begin
          x_r[i] <= x_p + ys;
          y_r[i] <= y_p - xs;
          z_r[i] <= z_p + ATAN_TURNS[i];
        end else begin
          x_r[i] <= x_p - ys;
          y_r[i] <= y_p + xs;
          z_r[i] <= z_p - ATAN_TURNS[i];
        end
      end
    end
  end

  assign out_vld  = vld_r[BEARING_STAGES-1];
  assign out_z    = z_r[BEARING_STAGES-1];
  assign out_side = side_r[BEARING_STAGES-1];

endmodule

>>> src/camera_sector_detection_test.sv
// ----------------------------------------------------------------------------
// camera_sector_detection_test
// bearing and range test of a target against up to two camera sectors
// ----------------------------------------------------------------------------
// One word is taken per clock and one result word leaves per clock while the
// output is not stalled; the path runs through the 16-step cordic bearing
// pipeline plus difference, pre-rotation, rounding and compare stages. A
// stalled output parks at most one input word in a skid register, so
// in_tready is a registered signal. A camera register write takes effect once
// the sector ends and squared range have been registered from it.
module camera_sector_detection_test
  import csd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // observer_x, observer_y, target_x, target_y
  input  logic        in_tlast,   // last_target
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // seen_x, seen_y
  output logic        out_tuser,  // detected
  output logic        out_tlast,  // last_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic en;
  logic in_acc;

  // configuration
  logic [1:0]  count_r;
  logic [15:0] center_r [CAM_SETS];
  logic [15:0] width_r  [CAM_SETS];
  logic [15:0] range_r  [CAM_SETS];
  logic [15:0] lo_r     [CAM_SETS];
  logic [15:0] hi_r     [CAM_SETS];
  logic        wrap_r   [CAM_SETS];
  logic [31:0] rsq_r    [CAM_SETS];
  logic        cam_en_r [CAM_SETS];
  logic [1:0]  count_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= 2'd1;
      center_r[0] <= 16'd0;
      center_r[1] <= 16'd0;
      width_r[0]  <= 16'd16384;
      width_r[1]  <= 16'd16384;
      range_r[0]  <= 16'd5120;
      range_r[1]  <= 16'd5120;
    end else if (cfg_valid) begin
      case (csd_reg_t'(cfg_index))
        REG_COUNT:    count_r     <= cfg_data[1:0];
        REG_CENTER_0: center_r[0] <= cfg_data;
        REG_WIDTH_0:  width_r[0]  <= cfg_data;
        REG_RANGE_0:  range_r[0]  <= cfg_data;
        REG_CENTER_1: center_r[1] <= cfg_data;
        REG_WIDTH_1:  width_r[1]  <= cfg_data;
        REG_RANGE_1:  range_r[1]  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign count_sat = (count_r > 2'(CAM_USED)) ? 2'(CAM_USED) : count_r;

  // sector ends and squared range, refreshed every cycle
  for (genvar k = 0; k < CAM_SETS; k++) begin : g_cam
    logic [15:0] lo_nxt;
    logic [15:0] hi_nxt;
    assign lo_nxt = center_r[k] - {1'b0, width_r[k][15:1]};
    assign hi_nxt = center_r[k] + {1'b0, width_r[k][15:1]};
    always_ff @(posedge clk) begin
      lo_r[k]     <= lo_nxt;
      hi_r[k]     <= hi_nxt;
      wrap_r[k]   <= lo_nxt > hi_nxt;
      rsq_r[k]    <= 32'(range_r[k]) * 32'(range_r[k]);
      cam_en_r[k] <= 2'(k) < count_sat;
    end
  end

  // input skid
  logic        skid_full_r;
  logic [63:0] skid_data_r;
  logic        skid_last_r;
  logic        src_vld;
  logic [63:0] src_data;
  logic        src_last;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = !skid_full_r;
  assign in_acc    = in_tvalid && in_tready;
  assign src_vld   = skid_full_r || in_acc;
  assign src_data  = skid_full_r ? skid_data_r : in_tdata;
  assign src_last  = skid_full_r ? skid_last_r : in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (en) begin
      skid_full_r <= 1'b0;
    end else if (in_acc) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !en) begin
      skid_data_r <= in_tdata;
      skid_last_r <= in_tlast;
    end
  end

  // stage p0: differences
  logic               vld_p0_r;
  logic signed [16:0] dx_p0_r;
  logic signed [16:0] dy_p0_r;
  logic [15:0]        tx_p0_r;
  logic [15:0]        ty_p0_r;
  logic               last_p0_r;
  logic signed [16:0] dx_nxt;
  logic signed [16:0] dy_nxt;

  assign dx_nxt = $signed({src_data[47], src_data[47:32]})
                - $signed({src_data[15], src_data[15:0]});
  assign dy_nxt = $signed({src_data[63], src_data[63:48]})
                - $signed({src_data[31], src_data[31:16]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p0_r <= 1'b0;
    end else if (en) begin
      vld_p0_r <= src_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_p0_r   <= dx_nxt;
      dy_p0_r   <= dy_nxt;
      tx_p0_r   <= src_data[47:32];
      ty_p0_r   <= src_data[63:48];
      last_p0_r <= src_last;
    end
  end

  // stage p1: half-turn pre-rotation and squares
  logic                 vld_p1_r;
  logic signed [XW-1:0] x_p1_r;
  logic signed [XW-1:0] y_p1_r;
  logic [ZW-1:0]        z_p1_r;
  csd_side_t            side_p1_r;
  logic signed [XW-1:0] xs_nxt;
  logic signed [XW-1:0] ys_nxt;
  logic signed [33:0]   dx2_nxt;
  logic signed [33:0]   dy2_nxt;

  assign xs_nxt  = {{(XW-33){dx_p0_r[16]}}, dx_p0_r, 16'd0};
  assign ys_nxt  = {{(XW-33){dy_p0_r[16]}}, dy_p0_r, 16'd0};
  assign dx2_nxt = 34'(dx_p0_r) * 34'(dx_p0_r);
  assign dy2_nxt = 34'(dy_p0_r) * 34'(dy_p0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p1_r <= 1'b0;
    end else if (en) begin
      vld_p1_r <= vld_p0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dx_p0_r[16]) begin
        x_p1_r <= -xs_nxt;
        y_p1_r <= -ys_nxt;
        z_p1_r <= 32'h80000000;
      end else begin
        x_p1_r <= xs_nxt;
        y_p1_r <= ys_nxt;
        z_p1_r <= '0;
      end
      side_p1_r.tx   <= tx_p0_r;
      side_p1_r.ty   <= ty_p0_r;
      side_p1_r.last <= last_p0_r;
      side_p1_r.zero <= (dx_p0_r == '0) && (dy_p0_r == '0);
      side_p1_r.dx2  <= dx2_nxt[SQW-1:0];
      side_p1_r.dy2  <= dy2_nxt[SQW-1:0];
    end
  end

  // bearing steps
  logic          vld_c;
  logic [ZW-1:0] z_c;
  csd_side_t     side_c;

  csd_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_p1_r),
    .in_x     (x_p1_r),
    .in_y     (y_p1_r),
    .in_z     (z_p1_r),
    .in_side  (side_p1_r),
    .out_vld  (vld_c),
    .out_z    (z_c),
    .out_side (side_c)
  );

  // stage f1: rounded bearing and squared distance
  logic          vld_f1_r;
  logic [15:0]   bearing_f1_r;
  logic [SQW:0]  dist2_f1_r;
  logic [15:0]   tx_f1_r;
  logic [15:0]   ty_f1_r;
  logic          last_f1_r;
  logic [ZW-1:0] z_rnd;

  assign z_rnd = z_c + 32'h00008000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_f1_r <= 1'b0;
    end else if (en) begin
      vld_f1_r <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bearing_f1_r <= side_c.zero ? 16'd0 : z_rnd[31:16];
      dist2_f1_r   <= {1'b0, side_c.dx2} + {1'b0, side_c.dy2};
      tx_f1_r      <= side_c.tx;
      ty_f1_r      <= side_c.ty;
      last_f1_r    <= side_c.last;
    end
  end

  // stage f2: sector and range compare into the output register
  logic [CAM_SETS-1:0] hit;

  always_comb begin
    for (int k = 0; k < CAM_SETS; k++) begin
      hit[k] = cam_en_r[k]
            && (wrap_r[k] ? (bearing_f1_r >= lo_r[k] || bearing_f1_r <= hi_r[k])
                          : (bearing_f1_r >= lo_r[k] && bearing_f1_r <= hi_r[k]))
            && (dist2_f1_r <= {2'b00, rsq_r[k]});
    end
  end

  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;
  logic        out_tuser_r;
  logic        out_tlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vld_f1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {ty_f1_r, tx_f1_r};
      out_tuser_r <= |hit;
      out_tlast_r <= last_f1_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

>>> src/csd_chk.sv
// ----------------------------------------------------------------------------
// csd_chk
// port-level checks on the sector detection block
// ----------------------------------------------------------------------------
module csd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast,
  input logic        cfg_ready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // input only backs off after a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input ready dropped without output stall");

  // no result word straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result word present after reset");

  // configuration channel never blocks
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind camera_sector_detection_test csd_chk u_csd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_ready  (cfg_ready)
);

>>> sim/tb_camera_sector_detection_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_camera_sector_detection_test
// Streams observer/target words through the sector test and checks each
// result word against a cycle-free predictor. The predictor runs the same
// vectoring cordic bearing, the squared distance and the wrapped sector
// test on its own copy of the camera registers. Registers are reprogrammed
// only while nothing is in flight. Both stream sides idle at random, and
// one phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_camera_sector_detection_test;
  import csd_pkg::*;

  localparam int      CLK_PERIOD  = 12;
  localparam int      IDLE_PCT    = 17;
  localparam int      HOLD_CYCLES = 300;
  localparam int      STALL_LIMIT = 2000;
  localparam int      TAIL_CYCLES = 40;
  localparam int      TURN_STEPS  = 24;
  localparam logic [2:0] REG_NONE = 3'd7;

  localparam logic [31:0] TURN_TABLE [TURN_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic               last;
  } target_t;

  typedef struct {
    logic        detected;
    logic [15:0] sx;
    logic [15:0] sy;
    logic        last;
  } sighting_t;

  typedef struct {
    logic [2:0]  index;
    logic [15:0] data;
  } reg_write_t;

  typedef reg_write_t reg_list_t[$];

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  logic [1:0]  view_count;
  logic [15:0] view_center [CAM_SETS];
  logic [15:0] view_width  [CAM_SETS];
  logic [15:0] view_range  [CAM_SETS];

  sighting_t   pending_sightings[$];
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  bit          no_gaps      = 1'b0;
  bit          hold_request = 1'b0;

  camera_sector_detection_test dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] cordic_bearing(input longint dx, input longint dy);
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [31:0] z;
    logic [31:0] rounded;
    if (dx == 0 && dy == 0) return 16'd0;
    z = 32'd0;
    x = dx * 65536;
    y = dy * 65536;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < BEARING_STAGES && i < TURN_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + TURN_TABLE[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - TURN_TABLE[i];
      end
    end
    rounded = z + 32'h00008000;
    return rounded[31:16];
  endfunction

  function automatic bit in_sector(input logic [15:0] b, input logic [15:0] center,
                                   input logic [15:0] width);
    logic [15:0] half;
    logic [15:0] lo;
    logic [15:0] hi;
    half = width >> 1;
    lo   = center - half;
    hi   = center + half;
    if (lo > hi) return (b >= lo) || (b <= hi);
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic sighting_t predict_sighting(input target_t t);
    sighting_t   s;
    longint      dx;
    longint      dy;
    longint      dist2;
    logic [15:0] b;
    int          used;
    dx    = longint'(t.tx) - longint'(t.ox);
    dy    = longint'(t.ty) - longint'(t.oy);
    dist2 = dx * dx + dy * dy;
    b     = cordic_bearing(dx, dy);
    used  = view_count;
    if (used > MAX_CAMERAS) used = MAX_CAMERAS;
    if (used > CAM_SETS) used = CAM_SETS;
    s.detected = 1'b0;
    for (int k = 0; k < used; k++) begin
      if (in_sector(b, view_center[k], view_width[k]) &&
          dist2 <= longint'(view_range[k]) * longint'(view_range[k]))
        s.detected = 1'b1;
    end
    s.sx   = t.tx;
    s.sy   = t.ty;
    s.last = t.last;
    return s;
  endfunction

  function automatic void reset_views();
    view_count = 2'd1;
    for (int k = 0; k < CAM_SETS; k++) begin
      view_center[k] = 16'd0;
      view_width[k]  = 16'd16384;
      view_range[k]  = 16'd5120;
    end
  endfunction

  function automatic void shadow_write(input logic [2:0] index, input logic [15:0] data);
    case (index)
      REG_COUNT:    view_count     = data[1:0];
      REG_CENTER_0: view_center[0] = data;
      REG_WIDTH_0:  view_width[0]  = data;
      REG_RANGE_0:  view_range[0]  = data;
      REG_CENTER_1: view_center[1] = data;
      REG_WIDTH_1:  view_width[1]  = data;
      REG_RANGE_1:  view_range[1]  = data;
      default: ;
    endcase
  endfunction

  // ----------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input longint got, input longint want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    sighting_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sightings.size() == 0) begin
        report_mismatch("result word with no target pending");
      end else begin
        due = pending_sightings.pop_front();
        compare_field("detected", out_tuser, due.detected);
        compare_field("seen_x", out_tdata[15:0], due.sx);
        compare_field("seen_y", out_tdata[31:16], due.sy);
        compare_field("last_out", out_tlast, due.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_camera_sector_detection_test NOT OK");
        $finish;
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
      end else if (no_gaps) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ------------------------------------------------------------------- sender

  task automatic offer_target(input target_t t);
    sighting_t s;
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t.ty, t.tx, t.oy, t.ox};
    in_tlast  <= t.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    s = predict_sighting(t);
    pending_sightings = {pending_sightings, s};
  endtask

  task automatic offer_at(input int ox, input int oy, input int tx, input int ty,
                          input bit last);
    target_t t;
    t = '{16'(ox), 16'(oy), 16'(tx), 16'(ty), last};
    offer_target(t);
  endtask

  function automatic target_t random_target();
    target_t t;
    int      mode;
    int      s;
    int      ddx;
    int      ddy;
    mode = $urandom_range(0, 9);
    t.ox = 16'($urandom);
    t.oy = 16'($urandom);
    case (mode)
      0, 1:    s = 32768;
      8:       s = 2;
      default: s = $urandom_range(16, 9000);
    endcase
    ddx = int'($urandom_range(0, 2 * s)) - s;
    ddy = int'($urandom_range(0, 2 * s)) - s;
    if (mode == 7) begin
      if ($urandom_range(0, 1)) ddx = 0;
      else ddy = 0;
    end
    if (mode <= 1) begin
      t.tx = 16'($urandom);
      t.ty = 16'($urandom);
    end else begin
      t.tx = 16'(int'(t.ox) + ddx);
      t.ty = 16'(int'(t.oy) + ddy);
    end
    t.last = ($urandom_range(0, 3) == 0);
    return t;
  endfunction

  task automatic offer_random(input int count);
    for (int n = 0; n < count; n++) offer_target(random_target());
  endtask

  task automatic wait_for_sightings();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_sightings.size() != 0);
  endtask

  task automatic program_cameras(input reg_list_t words);
    wait_for_sightings();
    foreach (words[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= words[k].index;
      cfg_data  <= words[k].data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      shadow_write(words[k].index, words[k].data);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic reg_list_t with_write(input reg_list_t words, input logic [2:0] index,
                                           input logic [15:0] data);
    reg_write_t w;
    w.index = index;
    w.data  = data;
    return {words, w};
  endfunction

  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(256, 12000));
    endcase
  endfunction

  function automatic logic [15:0] pick_width();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic reg_list_t random_settings();
    reg_list_t words;
    words = with_write(words, REG_COUNT, {14'($urandom), 2'($urandom_range(0, 3))});
    words = with_write(words, REG_CENTER_0, 16'($urandom));
    words = with_write(words, REG_WIDTH_0, pick_width());
    words = with_write(words, REG_RANGE_0, pick_range());
    words = with_write(words, REG_CENTER_1, 16'($urandom));
    words = with_write(words, REG_WIDTH_1, pick_width());
    words = with_write(words, REG_RANGE_1, pick_range());
    if ($urandom_range(0, 3) == 0) words = with_write(words, REG_NONE, 16'($urandom));
    return words;
  endfunction

  // -------------------------------------------------------------------- tests

  // reset camera: count 1, sector -45..+45 degrees, 20 m range
  task automatic test_reset_geometry();
    offer_at(0, 0, 0, 0, 1'b0);
    offer_at(-32768, -32768, -32768, -32768, 1'b1);
    offer_at(0, 0, 5120, 0, 1'b0);
    offer_at(0, 0, 5121, 0, 1'b0);
    offer_at(0, 0, -1000, 0, 1'b0);
    offer_at(0, 0, 0, 1000, 1'b0);
    offer_at(0, 0, 0, -1000, 1'b1);
    offer_at(0, 0, 1000, 1000, 1'b0);
    offer_at(0, 0, 1000, -1000, 1'b0);
    offer_at(0, 0, 3620, 3620, 1'b0);
    offer_at(0, 0, 1, 0, 1'b0);
    offer_at(0, 0, -1, 0, 1'b0);
    offer_at(0, 0, 0, -1, 1'b0);
    offer_at(0, 0, -1, -1, 1'b1);
    offer_at(-32768, 0, 32767, 0, 1'b0);
    offer_at(32767, 0, -32768, 0, 1'b0);
    offer_at(0, -32768, 0, 32767, 1'b0);
    offer_at(0, 32767, 0, -32768, 1'b0);
    offer_at(32767, 32767, -32768, -32768, 1'b0);
    offer_at(-32768, 32767, 32767, -32768, 1'b1);
  endtask

  task automatic test_register_extremes();
    reg_list_t words;
    words = with_write(words, REG_COUNT, 16'hFFFC);
    program_cameras(words);
    offer_at(0, 0, 0, 0, 1'b1);
    offer_at(100, 100, 200, 100, 1'b0);
    offer_random(4);

    // count 3 saturates; camera 0 is a single point, camera 1 all but one angle
    words.delete();
    words = with_write(words, REG_COUNT, 16'h0003);
    words = with_write(words, REG_CENTER_0, 16'h0000);
    words = with_write(words, REG_WIDTH_0, 16'h0000);
    words = with_write(words, REG_RANGE_0, 16'h0000);
    words = with_write(words, REG_CENTER_1, 16'h8000);
    words = with_write(words, REG_WIDTH_1, 16'hFFFF);
    words = with_write(words, REG_RANGE_1, 16'hFFFF);
    words = with_write(words, REG_NONE, 16'h0001);
    program_cameras(words);
    offer_at(0, 0, 0, 0, 1'b0);
    offer_at(0, 0, -1000, 0, 1'b0);
    offer_at(0, 0, 1000, 0, 1'b0);
    offer_at(-32768, -32768, 32767, 32767, 1'b1);
    offer_random(4);

    words.delete();
    words = with_write(words, REG_COUNT, 16'h0002);
    words = with_write(words, REG_CENTER_0, 16'hFFFF);
    words = with_write(words, REG_WIDTH_0, 16'h0001);
    words = with_write(words, REG_RANGE_0, 16'h0001);
    program_cameras(words);
    offer_at(0, 0, 1, 0, 1'b0);
    offer_at(0, 0, 0, 1, 1'b1);
    offer_random(4);
  endtask

  task automatic test_random_phases(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      program_cameras(random_settings());
      no_gaps = (p == 2);
      offer_random(per_phase);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_output_hold();
    program_cameras(random_settings());
    no_gaps      = 1'b1;
    hold_request = 1'b1;
    offer_random(80);
    no_gaps      = 1'b0;
  endtask

  initial begin
    reset_views();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_geometry();
    test_register_extremes();
    test_random_phases(6, 170);
    test_output_hold();
    wait_for_sightings();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_sightings.size() == 0) begin
      $display("tb_camera_sector_detection_test OK");
    end else begin
      $display("tb_camera_sector_detection_test NOT OK");
    end
    $finish;
  end

endmodule
